/* rtl/core/obox_pkg.sv */
// ---------------------------------------------------------------------------
// obox_pkg - shared types for the oriented box overlap test
// Names the four separating axes that the projection and decide stages work on side by side.
// ---------------------------------------------------------------------------
`default_nettype none

package obox_pkg;

   // Axes under test: box A x and y, box B x and y
   typedef enum logic [1:0] {
      AXIS_AX,
      AXIS_AY,
      AXIS_BX,
      AXIS_BY
   } axis_type;

   localparam int NUM_AXES = 4;

endpackage

`default_nettype wire

/* rtl/core/obox_front.sv */
// ---------------------------------------------------------------------------
// obox_front - first pipeline stage
// Centre difference and the four axis-by-axis products of the two boxes.
// ---------------------------------------------------------------------------
`default_nettype none

module obox_front #(
   parameter int CW = 24,
   parameter int UW = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [CW-1:0]     a_center_x,
   input  wire logic [CW-1:0]     a_center_y,
   input  wire logic [UW-1:0]     a_axis_cos,
   input  wire logic [UW-1:0]     a_axis_sin,
   input  wire logic [CW-2:0]     a_half_width,
   input  wire logic [CW-2:0]     a_half_height,
   input  wire logic [CW-1:0]     b_center_x,
   input  wire logic [CW-1:0]     b_center_y,
   input  wire logic [UW-1:0]     b_axis_cos,
   input  wire logic [UW-1:0]     b_axis_sin,
   input  wire logic [CW-2:0]     b_half_width,
   input  wire logic [CW-2:0]     b_half_height,
   output logic                   out_valid,
   output logic [CW:0]            out_dx,
   output logic [CW:0]            out_dy,
   output logic [UW-1:0]          out_a_cos,
   output logic [UW-1:0]          out_a_sin,
   output logic [UW-1:0]          out_b_cos,
   output logic [UW-1:0]          out_b_sin,
   output logic [CW-2:0]          out_a_hw,
   output logic [CW-2:0]          out_a_hh,
   output logic [CW-2:0]          out_b_hw,
   output logic [CW-2:0]          out_b_hh,
   output logic [2*UW-1:0]        out_acbc,
   output logic [2*UW-1:0]        out_asbs,
   output logic [2*UW-1:0]        out_acbs,
   output logic [2*UW-1:0]        out_asbc
);

   localparam int DW  = CW + 1;
   localparam int APW = 2 * UW;

   logic            valid_ff;
   logic [DW-1:0]   dx_in, dx_ff, dy_in, dy_ff;
   logic [APW-1:0]  acbc_in, acbc_ff, asbs_in, asbs_ff;
   logic [APW-1:0]  acbs_in, acbs_ff, asbc_in, asbc_ff;
   logic [UW-1:0]   a_cos_ff, a_sin_ff, b_cos_ff, b_sin_ff;
   logic [CW-2:0]   a_hw_ff, a_hh_ff, b_hw_ff, b_hh_ff;

   always_comb begin
      dx_in   = {a_center_x[CW-1], a_center_x} - {b_center_x[CW-1], b_center_x};
      dy_in   = {a_center_y[CW-1], a_center_y} - {b_center_y[CW-1], b_center_y};
      acbc_in = $signed(a_axis_cos) * $signed(b_axis_cos);
      asbs_in = $signed(a_axis_sin) * $signed(b_axis_sin);
      acbs_in = $signed(a_axis_cos) * $signed(b_axis_sin);
      asbc_in = $signed(a_axis_sin) * $signed(b_axis_cos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         acbc_ff  <= acbc_in;
         asbs_ff  <= asbs_in;
         acbs_ff  <= acbs_in;
         asbc_ff  <= asbc_in;
         a_cos_ff <= a_axis_cos;
         a_sin_ff <= a_axis_sin;
         b_cos_ff <= b_axis_cos;
         b_sin_ff <= b_axis_sin;
         a_hw_ff  <= a_half_width;
         a_hh_ff  <= a_half_height;
         b_hw_ff  <= b_half_width;
         b_hh_ff  <= b_half_height;
      end
   end

   assign out_valid = valid_ff;
   assign out_dx    = dx_ff;
   assign out_dy    = dy_ff;
   assign out_a_cos = a_cos_ff;
   assign out_a_sin = a_sin_ff;
   assign out_b_cos = b_cos_ff;
   assign out_b_sin = b_sin_ff;
   assign out_a_hw  = a_hw_ff;
   assign out_a_hh  = a_hh_ff;
   assign out_b_hw  = b_hw_ff;
   assign out_b_hh  = b_hh_ff;
   assign out_acbc  = acbc_ff;
   assign out_asbs  = asbs_ff;
   assign out_acbs  = acbs_ff;
   assign out_asbc  = asbc_ff;

endmodule

`default_nettype wire

/* rtl/core/obox_project.sv */
// ---------------------------------------------------------------------------
// obox_project - projection stages two and three
// Centre-difference projections onto the four axes, the shared dot and
// cross magnitudes, and the split radius products.
// ---------------------------------------------------------------------------
`default_nettype none

module obox_project #(
   parameter int CW = 24,
   parameter int UW = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          en,
   input  wire logic                                          in_valid,
   input  wire logic [CW:0]                                   dx,
   input  wire logic [CW:0]                                   dy,
   input  wire logic [UW-1:0]                                 a_cos,
   input  wire logic [UW-1:0]                                 a_sin,
   input  wire logic [UW-1:0]                                 b_cos,
   input  wire logic [UW-1:0]                                 b_sin,
   input  wire logic [CW-2:0]                                 a_hw,
   input  wire logic [CW-2:0]                                 a_hh,
   input  wire logic [CW-2:0]                                 b_hw,
   input  wire logic [CW-2:0]                                 b_hh,
   input  wire logic [2*UW-1:0]                               acbc,
   input  wire logic [2*UW-1:0]                               asbs,
   input  wire logic [2*UW-1:0]                               acbs,
   input  wire logic [2*UW-1:0]                               asbc,
   output logic                                               out_valid,
   output logic [obox_pkg::NUM_AXES-1:0][CW+UW+1:0]           out_dist,
   output logic [obox_pkg::NUM_AXES-1:0][CW-2:0]              out_own,
   output logic [obox_pkg::NUM_AXES-1:0][UW+CW-1:0]           out_pdl,
   output logic [obox_pkg::NUM_AXES-1:0][UW+CW-2:0]           out_pdh,
   output logic [obox_pkg::NUM_AXES-1:0][UW+CW-1:0]           out_pcl,
   output logic [obox_pkg::NUM_AXES-1:0][UW+CW-2:0]           out_pch
);

   localparam int NA  = obox_pkg::NUM_AXES;
   localparam int HW  = CW - 1;
   localparam int DPW = CW + 1 + UW;
   localparam int DMW = DPW + 1;
   localparam int AMW = 2 * UW + 1;
   localparam int LOW = UW + 1;
   localparam int HIW = AMW - LOW;

   // stage two
   logic                    v2_ff;
   logic [NA-1:0][DPW-1:0]  pa_in, pa_ff, pb_in, pb_ff;
   logic [AMW-1:0]          dot_s, cross_s;
   logic [AMW-1:0]          dot_in, dot_ff, cross_in, cross_ff;
   logic [HW-1:0]           a_hw2_ff, a_hh2_ff, b_hw2_ff, b_hh2_ff;

   // stage three
   logic                    v3_ff;
   logic [NA-1:0][DMW-1:0]  dsum;
   logic [NA-1:0][DMW-1:0]  dist_in, dist_ff;
   logic [NA-1:0][HW-1:0]   hd, hc, own_in, own_ff;
   logic [NA-1:0][LOW+HW-1:0] pdl_in, pdl_ff, pcl_in, pcl_ff;
   logic [NA-1:0][HIW+HW-1:0] pdh_in, pdh_ff, pch_in, pch_ff;

   // Projections of the centre difference; y axes are (-sin, cos)
   always_comb begin
      pa_in[obox_pkg::AXIS_AX] = $signed(dx) * $signed(a_cos);
      pb_in[obox_pkg::AXIS_AX] = $signed(dy) * $signed(a_sin);
      pa_in[obox_pkg::AXIS_AY] = $signed(dy) * $signed(a_cos);
      pb_in[obox_pkg::AXIS_AY] = $signed(dx) * $signed(a_sin);
      pa_in[obox_pkg::AXIS_BX] = $signed(dx) * $signed(b_cos);
      pb_in[obox_pkg::AXIS_BX] = $signed(dy) * $signed(b_sin);
      pa_in[obox_pkg::AXIS_BY] = $signed(dy) * $signed(b_cos);
      pb_in[obox_pkg::AXIS_BY] = $signed(dx) * $signed(b_sin);

      // |A.x . B.x| and |A.x x B.x| cover every cross-box projection
      dot_s    = {acbc[2*UW-1], acbc} + {asbs[2*UW-1], asbs};
      cross_s  = {acbs[2*UW-1], acbs} - {asbc[2*UW-1], asbc};
      dot_in   = dot_s[AMW-1] ? (~dot_s + 1'b1) : dot_s;
      cross_in = cross_s[AMW-1] ? (~cross_s + 1'b1) : cross_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= in_valid;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         dot_ff   <= dot_in;
         cross_ff <= cross_in;
         a_hw2_ff <= a_hw;
         a_hh2_ff <= a_hh;
         b_hw2_ff <= b_hw;
         b_hh2_ff <= b_hh;
      end
   end

   always_comb begin
      dsum[obox_pkg::AXIS_AX] = {pa_ff[obox_pkg::AXIS_AX][DPW-1], pa_ff[obox_pkg::AXIS_AX]}
                              + {pb_ff[obox_pkg::AXIS_AX][DPW-1], pb_ff[obox_pkg::AXIS_AX]};
      dsum[obox_pkg::AXIS_AY] = {pa_ff[obox_pkg::AXIS_AY][DPW-1], pa_ff[obox_pkg::AXIS_AY]}
                              - {pb_ff[obox_pkg::AXIS_AY][DPW-1], pb_ff[obox_pkg::AXIS_AY]};
      dsum[obox_pkg::AXIS_BX] = {pa_ff[obox_pkg::AXIS_BX][DPW-1], pa_ff[obox_pkg::AXIS_BX]}
                              + {pb_ff[obox_pkg::AXIS_BX][DPW-1], pb_ff[obox_pkg::AXIS_BX]};
      dsum[obox_pkg::AXIS_BY] = {pa_ff[obox_pkg::AXIS_BY][DPW-1], pa_ff[obox_pkg::AXIS_BY]}
                              - {pb_ff[obox_pkg::AXIS_BY][DPW-1], pb_ff[obox_pkg::AXIS_BY]};

      // own half-length, and the halves that weigh |dot| and |cross|
      own_in[obox_pkg::AXIS_AX] = a_hw2_ff;
      hd[obox_pkg::AXIS_AX]     = b_hw2_ff;
      hc[obox_pkg::AXIS_AX]     = b_hh2_ff;
      own_in[obox_pkg::AXIS_AY] = a_hh2_ff;
      hd[obox_pkg::AXIS_AY]     = b_hh2_ff;
      hc[obox_pkg::AXIS_AY]     = b_hw2_ff;
      own_in[obox_pkg::AXIS_BX] = b_hw2_ff;
      hd[obox_pkg::AXIS_BX]     = a_hw2_ff;
      hc[obox_pkg::AXIS_BX]     = a_hh2_ff;
      own_in[obox_pkg::AXIS_BY] = b_hh2_ff;
      hd[obox_pkg::AXIS_BY]     = a_hh2_ff;
      hc[obox_pkg::AXIS_BY]     = a_hw2_ff;

      for (int k = 0; k < NA; k++) begin
         dist_in[k] = dsum[k][DMW-1] ? (~dsum[k] + 1'b1) : dsum[k];
         pdl_in[k]  = dot_ff[LOW-1:0] * hd[k];
         pdh_in[k]  = dot_ff[AMW-1:LOW] * hd[k];
         pcl_in[k]  = cross_ff[LOW-1:0] * hc[k];
         pch_in[k]  = cross_ff[AMW-1:LOW] * hc[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
         own_ff  <= own_in;
         pdl_ff  <= pdl_in;
         pdh_ff  <= pdh_in;
         pcl_ff  <= pcl_in;
         pch_ff  <= pch_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_dist  = dist_ff;
   assign out_own   = own_ff;
   assign out_pdl   = pdl_ff;
   assign out_pdh   = pdh_ff;
   assign out_pcl   = pcl_ff;
   assign out_pch   = pch_ff;

endmodule

`default_nettype wire

/* rtl/core/obox_decide.sv */
// ---------------------------------------------------------------------------
// obox_decide - stages four to six
// Rebuild the radius products, add the radius sums and compare each
// projected distance against its sum; any separating axis clears overlap.
// ---------------------------------------------------------------------------
`default_nettype none

module obox_decide #(
   parameter int CW = 24,
   parameter int UW = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          en,
   input  wire logic                                          in_valid,
   input  wire logic [obox_pkg::NUM_AXES-1:0][CW+UW+1:0]      proj_dist,
   input  wire logic [obox_pkg::NUM_AXES-1:0][CW-2:0]         own,
   input  wire logic [obox_pkg::NUM_AXES-1:0][UW+CW-1:0]      pdl,
   input  wire logic [obox_pkg::NUM_AXES-1:0][UW+CW-2:0]      pdh,
   input  wire logic [obox_pkg::NUM_AXES-1:0][UW+CW-1:0]      pcl,
   input  wire logic [obox_pkg::NUM_AXES-1:0][UW+CW-2:0]      pch,
   output logic                                               out_valid,
   output logic                                               out_overlap
);

   localparam int NA  = obox_pkg::NUM_AXES;
   localparam int HW  = CW - 1;
   localparam int DMW = CW + UW + 2;
   localparam int LOW = UW + 1;
   localparam int RPW = 2 * UW + 1 + HW;
   localparam int FR  = UW - 2;
   localparam int RW  = CW + 2 * UW + 2;

   logic                    v4_ff, v5_ff, v6_ff;
   logic [NA-1:0][RPW-1:0]  rd_in, rd_ff, rc_in, rc_ff;
   logic [NA-1:0][DMW-1:0]  dist4_ff, dist5_ff;
   logic [NA-1:0][HW-1:0]   own4_ff;
   logic [NA-1:0][RW-1:0]   rhs_in, rhs_ff;
   logic [NA-1:0]           sep;
   logic                    overlap_in, overlap_ff;

   // Stitch the high and low partial products back together, form the radius sums and compare per axis
   always_comb begin
      for (int k = 0; k < NA; k++) begin
         rd_in[k]  = {pdh[k], {LOW{1'b0}}} + RPW'(pdl[k]);
         rc_in[k]  = {pch[k], {LOW{1'b0}}} + RPW'(pcl[k]);
         rhs_in[k] = RW'({own4_ff[k], {(2 * FR){1'b0}}}) + RW'(rd_ff[k]) + RW'(rc_ff[k]);
         sep[k]    = RW'({dist5_ff[k], {FR{1'b0}}}) > rhs_ff[k];
      end
      overlap_in = ~|sep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff      <= rd_in;
         rc_ff      <= rc_in;
         dist4_ff   <= proj_dist;
         own4_ff    <= own;
         rhs_ff     <= rhs_in;
         dist5_ff   <= dist4_ff;
         overlap_ff <= overlap_in;
      end
   end

   assign out_valid   = v6_ff;
   assign out_overlap = overlap_ff;

endmodule

`default_nettype wire

/* rtl/core/oriented_box_overlap_test.sv */
// ---------------------------------------------------------------------------
// oriented_box_overlap_test - 2D oriented box separating axis test
// Tests two oriented rectangles against the four box axes and reports
// whether they overlap (touching counts as overlap).
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one beat carries both boxes - centre (signed
//   Q16.8), unit x-axis (cos, sin) in signed Q1.14, and the two unsigned
//   half-lengths. A beat is taken on a rising edge with req_valid high and
//   req_stall low.
//   Response channel (rsp_*): one beat per request, in order, carrying
//   rsp_overlap. The beat is taken when rsp_valid is high and rsp_stall low.
//   Throughput: one box pair per cycle while the response side does not
//   stall; every beat walks through the six-stage multiply/add pipeline.
//   Stall: while a response waits with rsp_stall high the whole pipeline
//   holds, and req_stall is raised so no request beat is taken; nothing is
//   dropped or repeated. Bubbles ahead of the output are not squeezed out.
//   Reset (synchronous, active high) empties the pipeline and holds
//   req_stall high; the first request can be taken on the cycle after
//   reset falls.
// ---------------------------------------------------------------------------
`default_nettype none

module oriented_box_overlap_test #(
   parameter int COORD_WIDTH = 24,
   parameter int UNIT_WIDTH  = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [COORD_WIDTH-1:0]  req_a_center_x,
   input  wire logic [COORD_WIDTH-1:0]  req_a_center_y,
   input  wire logic [UNIT_WIDTH-1:0]   req_a_axis_cos,
   input  wire logic [UNIT_WIDTH-1:0]   req_a_axis_sin,
   input  wire logic [COORD_WIDTH-2:0]  req_a_half_width,
   input  wire logic [COORD_WIDTH-2:0]  req_a_half_height,
   input  wire logic [COORD_WIDTH-1:0]  req_b_center_x,
   input  wire logic [COORD_WIDTH-1:0]  req_b_center_y,
   input  wire logic [UNIT_WIDTH-1:0]   req_b_axis_cos,
   input  wire logic [UNIT_WIDTH-1:0]   req_b_axis_sin,
   input  wire logic [COORD_WIDTH-2:0]  req_b_half_width,
   input  wire logic [COORD_WIDTH-2:0]  req_b_half_height,
   // response channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_overlap
);

   localparam int CW  = COORD_WIDTH;
   localparam int UW  = UNIT_WIDTH;
   localparam int NA  = obox_pkg::NUM_AXES;

   logic                      en;
   logic                      v1, v3, v6;

   // stage one outputs
   logic [CW:0]               dx, dy;
   logic [UW-1:0]             a_cos, a_sin, b_cos, b_sin;
   logic [CW-2:0]             a_hw, a_hh, b_hw, b_hh;
   logic [2*UW-1:0]           acbc, asbs, acbs, asbc;

   // stage three outputs
   logic [NA-1:0][CW+UW+1:0]  proj_dist;
   logic [NA-1:0][CW-2:0]     own;
   logic [NA-1:0][UW+CW-1:0]  pdl, pcl;
   logic [NA-1:0][UW+CW-2:0]  pdh, pch;

   logic                      overlap;

   // Advance every stage together unless a finished beat is held at the
   // output; hold the whole pipe (and the request side) while it waits.
   // Refuse request beats during reset.
   assign en        = !(v6 && rsp_stall);
   assign req_stall = reset || !en;

   obox_front #(
      .CW (CW),
      .UW (UW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_valid),
      .a_center_x    (req_a_center_x),
      .a_center_y    (req_a_center_y),
      .a_axis_cos    (req_a_axis_cos),
      .a_axis_sin    (req_a_axis_sin),
      .a_half_width  (req_a_half_width),
      .a_half_height (req_a_half_height),
      .b_center_x    (req_b_center_x),
      .b_center_y    (req_b_center_y),
      .b_axis_cos    (req_b_axis_cos),
      .b_axis_sin    (req_b_axis_sin),
      .b_half_width  (req_b_half_width),
      .b_half_height (req_b_half_height),
      .out_valid     (v1),
      .out_dx        (dx),
      .out_dy        (dy),
      .out_a_cos     (a_cos),
      .out_a_sin     (a_sin),
      .out_b_cos     (b_cos),
      .out_b_sin     (b_sin),
      .out_a_hw      (a_hw),
      .out_a_hh      (a_hh),
      .out_b_hw      (b_hw),
      .out_b_hh      (b_hh),
      .out_acbc      (acbc),
      .out_asbs      (asbs),
      .out_acbs      (acbs),
      .out_asbc      (asbc)
   );

   // Projection stages: distance products, then magnitudes and radius
   // partial products (split so each multiplier stays narrow).
   obox_project #(
      .CW (CW),
      .UW (UW)
   ) u_project (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1),
      .dx        (dx),
      .dy        (dy),
      .a_cos     (a_cos),
      .a_sin     (a_sin),
      .b_cos     (b_cos),
      .b_sin     (b_sin),
      .a_hw      (a_hw),
      .a_hh      (a_hh),
      .b_hw      (b_hw),
      .b_hh      (b_hh),
      .acbc      (acbc),
      .asbs      (asbs),
      .acbs      (acbs),
      .asbc      (asbc),
      .out_valid (v3),
      .out_dist  (proj_dist),
      .out_own   (own),
      .out_pdl   (pdl),
      .out_pdh   (pdh),
      .out_pcl   (pcl),
      .out_pch   (pch)
   );

   // Product rebuild, radius sums and the final compare; the last stage is the output
   // register of the response channel.
   obox_decide #(
      .CW (CW),
      .UW (UW)
   ) u_decide (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (v3),
      .proj_dist   (proj_dist),
      .own         (own),
      .pdl         (pdl),
      .pdh         (pdh),
      .pcl         (pcl),
      .pch         (pch),
      .out_valid   (v6),
      .out_overlap (overlap)
   );

   assign rsp_valid   = v6;
   assign rsp_overlap = overlap;

   // Outside reset, the request side is only held off by a waiting response beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v6 && rsp_stall))
      else $error("request stalled without a held response beat");

   // A held pipe keeps the occupancy of stages one and three
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable({v1, v3}))
      else $error("pipeline occupancy changed while held");

   // Reset leaves no response beat behind
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !v1 && !v3))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
